// ===== rtl/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg: shared types and constants for the unicycle trajectory tracker
// Request structs, controller/datapath command and status, micro-op codes
// and the micro-program that the controller steps through.
// ----------------------------------------------------------------------------
package utt_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF  = 16;

	localparam int ITER_W = 6;
	localparam int PC_W   = 6;

	// opcodes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_SECOND = 2'd1;
	localparam logic [1:0] OP_STEP   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PERIOD     = 2'd0;
	localparam logic [1:0] REG_INV_PERIOD = 2'd1;
	localparam logic [1:0] REG_VEL_GAIN   = 2'd2;
	localparam logic [1:0] REG_POS_GAIN   = 2'd3;

	localparam logic [15:0] PERIOD_RST     = 16'd16384;
	localparam logic [31:0] INV_PERIOD_RST = 32'd262144;
	localparam logic [15:0] VEL_GAIN_RST   = 16'd1280;
	localparam logic [15:0] POS_GAIN_RST   = 16'd256;

	// program entry points
	localparam logic [PC_W-1:0] PC_START  = 6'd0;
	localparam logic [PC_W-1:0] PC_SECOND = 6'd1;
	localparam logic [PC_W-1:0] PC_STEP   = 6'd8;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] measured_speed;
		logic signed [31:0] measured_turn_rate;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] speed_command;
		logic signed [31:0] turn_command;
		logic               divide_fault;
	} out_item_t;

	typedef enum logic [5:0] {
		U_NOP, U_LD0, U_D_PRE1, U_AT_INIT, U_AT_ITER, U_AT_DONE, U_M_DINV, U_M_EINV,
		U_ST1, U_M_VT, U_M_WT, U_PHI, U_M_PHI, U_ANG, U_CS_MID, U_CS_ITER, U_CS_DONE,
		U_M_DC, U_M_DS, U_POSY, U_CS_HEAD, U_M_VC, U_M_VS, U_D_TX, U_D_TY, U_D_AX,
		U_D_AY, U_D_EX, U_M_KVD, U_M_KPEX, U_FAX, U_M_KPEY, U_FAY, U_M_AXC, U_M_AYS,
		U_M_AYC, U_M_AXS, U_A2, U_M_A1T, U_VCMD, U_DIV_INIT, U_DIV_ITER, U_FIN
	} uop_t;

	typedef struct packed {
		uop_t              uop;
		logic [ITER_W-1:0] iter;
		logic              latch;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	function automatic uop_t program_uop(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = U_LD0;
			6'd1:  u = U_D_PRE1;
			6'd2:  u = U_AT_INIT;
			6'd3:  u = U_AT_ITER;
			6'd4:  u = U_AT_DONE;
			6'd5:  u = U_M_DINV;
			6'd6:  u = U_M_EINV;
			6'd7:  u = U_ST1;
			6'd8:  u = U_M_VT;
			6'd9:  u = U_M_WT;
			6'd10: u = U_PHI;
			6'd11: u = U_M_PHI;
			6'd12: u = U_ANG;
			6'd13: u = U_CS_MID;
			6'd14: u = U_CS_ITER;
			6'd15: u = U_CS_DONE;
			6'd16: u = U_M_DC;
			6'd17: u = U_M_DS;
			6'd18: u = U_POSY;
			6'd19: u = U_CS_HEAD;
			6'd20: u = U_CS_ITER;
			6'd21: u = U_CS_DONE;
			6'd22: u = U_M_VC;
			6'd23: u = U_M_VS;
			6'd24: u = U_D_TX;
			6'd25: u = U_M_DINV;
			6'd26: u = U_D_TY;
			6'd27: u = U_M_DINV;
			6'd28: u = U_D_AX;
			6'd29: u = U_M_DINV;
			6'd30: u = U_D_AY;
			6'd31: u = U_M_DINV;
			6'd32: u = U_D_EX;
			6'd33: u = U_M_KVD;
			6'd34: u = U_M_KPEX;
			6'd35: u = U_FAX;
			6'd36: u = U_M_KVD;
			6'd37: u = U_M_KPEY;
			6'd38: u = U_FAY;
			6'd39: u = U_M_AXC;
			6'd40: u = U_M_AYS;
			6'd41: u = U_M_AYC;
			6'd42: u = U_M_AXS;
			6'd43: u = U_A2;
			6'd44: u = U_M_A1T;
			6'd45: u = U_VCMD;
			6'd46: u = U_DIV_INIT;
			6'd47: u = U_DIV_ITER;
			6'd48: u = U_FIN;
			default: u = U_NOP;
		endcase
		return u;
	endfunction

	// CORDIC step angles in 32-bit turn units
	function automatic logic [31:0] turn_angle(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10680862;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/utt_ctrl.sv =====
// ----------------------------------------------------------------------------
// utt_ctrl: tracker sequencer
// Accepts requests, picks the micro-program by opcode and steps it, repeating
// CORDIC and divider micro-ops for their iteration counts.
// ----------------------------------------------------------------------------
module utt_ctrl #(
	parameter int FRACTION_BITS = utt_pkg::FRACTION_BITS_DEF,
	parameter int CORDIC_STEPS  = utt_pkg::CORDIC_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  utt_pkg::status_t status,
	output utt_pkg::cmd_t    cmd
);

	localparam logic [utt_pkg::ITER_W-1:0] DIV_LAST =
		utt_pkg::ITER_W'(32 + FRACTION_BITS - 1);
	localparam logic [utt_pkg::ITER_W-1:0] CORD_LAST = utt_pkg::ITER_W'(CORDIC_STEPS - 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t                      state_q;
	logic [utt_pkg::PC_W-1:0]    pc_q;
	logic [utt_pkg::ITER_W-1:0]  iter_q;
	utt_pkg::uop_t               uop_cur;
	logic                        is_loop, is_final, last_iter, hold, step_done, accept;

	always_comb begin
		uop_cur   = utt_pkg::program_uop(pc_q);
		is_loop   = (uop_cur == utt_pkg::U_AT_ITER) || (uop_cur == utt_pkg::U_CS_ITER) ||
			(uop_cur == utt_pkg::U_DIV_ITER);
		is_final  = (uop_cur == utt_pkg::U_LD0) || (uop_cur == utt_pkg::U_ST1) ||
			(uop_cur == utt_pkg::U_FIN);
		last_iter = iter_q == ((uop_cur == utt_pkg::U_DIV_ITER) ? DIV_LAST : CORD_LAST);
		// result can only retire once the output register is free
		hold      = (uop_cur == utt_pkg::U_FIN) && status.out_busy;
		step_done = !hold && (!is_loop || last_iter);
		accept    = in_valid && (state_q == S_IDLE);
	end

	assign in_stall  = state_q != S_IDLE;
	assign cmd.uop   = (state_q == S_RUN && !hold) ? uop_cur : utt_pkg::U_NOP;
	assign cmd.iter  = iter_q;
	assign cmd.latch = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			iter_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					iter_q <= '0;
					if (accept) begin
						case (opcode)
							utt_pkg::OP_START: begin
								pc_q    <= utt_pkg::PC_START;
								state_q <= S_RUN;
							end
							utt_pkg::OP_SECOND: begin
								pc_q    <= utt_pkg::PC_SECOND;
								state_q <= S_RUN;
							end
							utt_pkg::OP_STEP: begin
								pc_q    <= utt_pkg::PC_STEP;
								state_q <= S_RUN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RUN: begin
					if (step_done) begin
						iter_q <= '0;
						pc_q   <= pc_q + 1'b1;
						if (is_final)
							state_q <= S_IDLE;
					end else if (is_loop) begin
						iter_q <= iter_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/utt_datapath.sv =====
// ----------------------------------------------------------------------------
// utt_datapath: tracker arithmetic
// Shared 33x33 multiplier, shared CORDIC rotator (sin/cos and atan2 modes),
// restoring divider, tracker state, configuration and output register.
// ----------------------------------------------------------------------------
module utt_datapath #(
	parameter int FRACTION_BITS = utt_pkg::FRACTION_BITS_DEF,
	parameter int ANGLE_BITS    = utt_pkg::ANGLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  utt_pkg::cmd_t     cmd,
	output utt_pkg::status_t  status,
	input  utt_pkg::in_item_t in_data,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output utt_pkg::out_item_t out_data
);

	localparam int F   = FRACTION_BITS;
	localparam int A   = ANGLE_BITS;
	localparam int SH  = 32 + F - A;
	localparam int DW  = 32 + F;
	localparam int CSH = 30 - F;

	localparam logic signed [32:0] INV_TWO_PI = 33'sd683565276;
	localparam logic signed [59:0] CORDIC_X0  = 60'sd652032874;

	function automatic logic signed [67:0] x68(input logic signed [31:0] v);
		return {{36{v[31]}}, v};
	endfunction

	function automatic logic signed [67:0] x68w(input logic signed [65:0] v);
		return {{2{v[65]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647)
			return 32'sh7fffffff;
		if (v < -68'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	// configuration
	logic [15:0] period_q, vel_gain_q, pos_gain_q;
	logic [31:0] inv_period_q;

	// tracker state
	logic signed [31:0] pos_x_q, pos_y_q, ptx_q, pty_q, pvx_q, pvy_q, acc_q;
	logic [A-1:0]       heading_q;

	// working registers
	utt_pkg::in_item_t  in_q;
	logic signed [65:0] prod_q, sum_q;
	logic signed [31:0] delta_q, phi_q, c_q, s_q, d_q, e_q;
	logic signed [31:0] vx_q, vy_q, vxs_q, vys_q, axs_q, ays_q, ax_q, ay_q, a1_q, a2_q;
	logic signed [31:0] vcmd_q;
	logic [A:0]         phi_ang_q;
	logic signed [59:0] cx_q, cy_q;
	logic [31:0]        cz_q;
	logic               flip_q, azero_q;
	logic [32:0]        rem_q;
	logic [DW-1:0]      quo_q;
	logic [31:0]        dmag_q;
	logic               qneg_q, fault_q;
	logic               out_valid_q;
	utt_pkg::out_item_t out_q;

	// combinational helpers
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_d;
	logic [A-1:0]       ang;
	logic [31:0]        t_ang, u_ang, step_ang;
	logic signed [31:0] tz;
	logic               sc_flip;
	logic signed [59:0] xs_sh, ys_sh, xf, yf, dx60, dy60;
	logic [32:0]        rs;
	logic               ge;
	logic [DW-1:0]      num_w;
	logic signed [DW:0] q_s;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.uop)
			utt_pkg::U_M_VT:   begin ma = sx33(in_q.measured_speed);     mb = {17'd0, period_q}; end
			utt_pkg::U_M_WT:   begin ma = sx33(in_q.measured_turn_rate); mb = {17'd0, period_q}; end
			utt_pkg::U_M_PHI:  begin ma = sx33(phi_q);   mb = INV_TWO_PI; end
			utt_pkg::U_M_DC:   begin ma = sx33(delta_q); mb = sx33(c_q); end
			utt_pkg::U_M_DS:   begin ma = sx33(delta_q); mb = sx33(s_q); end
			utt_pkg::U_M_VC:   begin ma = sx33(in_q.measured_speed); mb = sx33(c_q); end
			utt_pkg::U_M_VS:   begin ma = sx33(in_q.measured_speed); mb = sx33(s_q); end
			utt_pkg::U_M_DINV: begin ma = sx33(d_q); mb = {1'b0, inv_period_q}; end
			utt_pkg::U_M_EINV: begin ma = sx33(e_q); mb = {1'b0, inv_period_q}; end
			utt_pkg::U_M_KVD:  begin ma = sx33(d_q); mb = {17'd0, vel_gain_q}; end
			utt_pkg::U_M_KPEX,
			utt_pkg::U_M_KPEY: begin ma = sx33(e_q); mb = {17'd0, pos_gain_q}; end
			utt_pkg::U_M_AXC:  begin ma = sx33(ax_q); mb = sx33(c_q); end
			utt_pkg::U_M_AYS:  begin ma = sx33(ay_q); mb = sx33(s_q); end
			utt_pkg::U_M_AYC:  begin ma = sx33(ay_q); mb = sx33(c_q); end
			utt_pkg::U_M_AXS:  begin ma = sx33(ax_q); mb = sx33(s_q); end
			utt_pkg::U_M_A1T:  begin ma = sx33(a1_q); mb = {17'd0, period_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
		prod_d = ma * mb;

		// sin/cos start: fold the angle into +-quarter turn
		ang      = (cmd.uop == utt_pkg::U_CS_MID) ? heading_q + phi_ang_q[A:1] : heading_q;
		t_ang    = {ang, {(32 - A){1'b0}}};
		tz       = t_ang;
		sc_flip  = (tz > 32'sd1073741824) || (tz < -32'sd1073741824);
		step_ang = utt_pkg::turn_angle(cmd.iter[4:0]);
		xs_sh    = cx_q >>> cmd.iter;
		ys_sh    = cy_q >>> cmd.iter;
		xf       = flip_q ? -cx_q : cx_q;
		yf       = flip_q ? -cy_q : cy_q;
		dx60     = {{4{d_q[31]}}, d_q, 24'd0};
		dy60     = {{4{e_q[31]}}, e_q, 24'd0};
		u_ang    = cz_q + (32'd1 << (31 - A));

		rs    = {rem_q[31:0], quo_q[DW-1]};
		ge    = rs >= {1'b0, dmag_q};
		num_w = {a2_q, {F{1'b0}}};
		q_s   = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	// configuration, tracker state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= utt_pkg::PERIOD_RST;
			inv_period_q <= utt_pkg::INV_PERIOD_RST;
			vel_gain_q   <= utt_pkg::VEL_GAIN_RST;
			pos_gain_q   <= utt_pkg::POS_GAIN_RST;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			heading_q    <= '0;
			ptx_q        <= '0;
			pty_q        <= '0;
			pvx_q        <= '0;
			pvy_q        <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					utt_pkg::REG_PERIOD:     period_q     <= cfg_data[15:0];
					utt_pkg::REG_INV_PERIOD: inv_period_q <= cfg_data;
					utt_pkg::REG_VEL_GAIN:   vel_gain_q   <= cfg_data[15:0];
					utt_pkg::REG_POS_GAIN:   pos_gain_q   <= cfg_data[15:0];
					default: period_q <= period_q;
				endcase
			end

			if (cmd.uop == utt_pkg::U_FIN)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (cmd.uop)
				utt_pkg::U_LD0: begin
					pos_x_q <= in_q.target_x;
					pos_y_q <= in_q.target_y;
					ptx_q   <= in_q.target_x;
					pty_q   <= in_q.target_y;
				end
				utt_pkg::U_AT_DONE: heading_q <= azero_q ? '0 : u_ang[31 -: A];
				utt_pkg::U_M_EINV:  pvx_q <= sat32(x68w(prod_q >>> 16));
				utt_pkg::U_ST1: begin
					pvy_q <= sat32(x68w(prod_q >>> 16));
					ptx_q <= in_q.target_x;
					pty_q <= in_q.target_y;
				end
				utt_pkg::U_M_DS: pos_x_q <= sat32(x68w(prod_q >>> F) + x68(pos_x_q));
				utt_pkg::U_POSY: begin
					pos_y_q   <= sat32(x68w(prod_q >>> F) + x68(pos_y_q));
					heading_q <= heading_q + phi_ang_q[A-1:0];
				end
				utt_pkg::U_FIN: begin
					acc_q <= vcmd_q;
					ptx_q <= in_q.target_x;
					pty_q <= in_q.target_y;
					pvx_q <= vxs_q;
					pvy_q <= vys_q;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.latch)
			in_q <= in_data;

		case (cmd.uop)
			utt_pkg::U_D_PRE1: begin
				d_q <= sat32(x68(in_q.target_x) - x68(ptx_q));
				e_q <= sat32(x68(in_q.target_y) - x68(pty_q));
			end
			utt_pkg::U_AT_INIT: begin
				azero_q <= (d_q == 32'sd0) && (e_q == 32'sd0);
				if (d_q[31]) begin
					cx_q <= -dx60;
					cy_q <= -dy60;
					cz_q <= 32'h80000000;
				end else begin
					cx_q <= dx60;
					cy_q <= dy60;
					cz_q <= 32'd0;
				end
			end
			utt_pkg::U_AT_ITER: begin
				if (!cy_q[59]) begin
					cx_q <= cx_q + ys_sh;
					cy_q <= cy_q - xs_sh;
					cz_q <= cz_q + step_ang;
				end else begin
					cx_q <= cx_q - ys_sh;
					cy_q <= cy_q + xs_sh;
					cz_q <= cz_q - step_ang;
				end
			end
			utt_pkg::U_M_WT: delta_q <= sat32(x68w(prod_q >>> 16));
			utt_pkg::U_PHI:  phi_q   <= sat32(x68w(prod_q >>> 16));
			utt_pkg::U_ANG:  phi_ang_q <= prod_q[SH +: A + 1];
			utt_pkg::U_CS_MID,
			utt_pkg::U_CS_HEAD: begin
				flip_q <= sc_flip;
				cz_q   <= sc_flip ? {~t_ang[31], t_ang[30:0]} : t_ang;
				cx_q   <= CORDIC_X0;
				cy_q   <= '0;
			end
			utt_pkg::U_CS_ITER: begin
				if (!cz_q[31]) begin
					cx_q <= cx_q - ys_sh;
					cy_q <= cy_q + xs_sh;
					cz_q <= cz_q - step_ang;
				end else begin
					cx_q <= cx_q + ys_sh;
					cy_q <= cy_q - xs_sh;
					cz_q <= cz_q + step_ang;
				end
			end
			utt_pkg::U_CS_DONE: begin
				c_q <= 32'(xf >>> CSH);
				s_q <= 32'(yf >>> CSH);
			end
			utt_pkg::U_D_TX: begin
				vy_q <= sat32(x68w(prod_q >>> F));
				d_q  <= sat32(x68(in_q.target_x) - x68(ptx_q));
			end
			utt_pkg::U_D_TY: begin
				vxs_q <= sat32(x68w(prod_q >>> 16));
				d_q   <= sat32(x68(in_q.target_y) - x68(pty_q));
			end
			utt_pkg::U_D_AX: begin
				vys_q <= sat32(x68w(prod_q >>> 16));
				d_q   <= sat32(x68(vxs_q) - x68(pvx_q));
			end
			utt_pkg::U_D_AY: begin
				axs_q <= sat32(x68w(prod_q >>> 16));
				d_q   <= sat32(x68(vys_q) - x68(pvy_q));
			end
			utt_pkg::U_D_EX: begin
				ays_q <= sat32(x68w(prod_q >>> 16));
				d_q   <= sat32(x68(vxs_q) - x68(vx_q));
				e_q   <= sat32(x68(in_q.target_x) - x68(pos_x_q));
			end
			utt_pkg::U_M_VS:   vx_q  <= sat32(x68w(prod_q >>> F));
			utt_pkg::U_M_KPEX: sum_q <= 66'(x68(axs_q) + x68w(prod_q >>> 8));
			utt_pkg::U_FAX: begin
				ax_q <= sat32(x68w(sum_q) + x68w(prod_q >>> 8));
				d_q  <= sat32(x68(vys_q) - x68(vy_q));
				e_q  <= sat32(x68(in_q.target_y) - x68(pos_y_q));
			end
			utt_pkg::U_M_KPEY: sum_q <= 66'(x68(ays_q) + x68w(prod_q >>> 8));
			utt_pkg::U_FAY:    ay_q  <= sat32(x68w(sum_q) + x68w(prod_q >>> 8));
			utt_pkg::U_M_AYS:  sum_q <= prod_q;
			utt_pkg::U_M_AYC:  a1_q  <= sat32((x68w(sum_q) + x68w(prod_q)) >>> F);
			utt_pkg::U_M_AXS:  sum_q <= prod_q;
			utt_pkg::U_A2:     a2_q  <= sat32((x68w(sum_q) - x68w(prod_q)) >>> F);
			utt_pkg::U_VCMD:   vcmd_q <= sat32(x68(acc_q) + x68w(prod_q >>> 16));
			utt_pkg::U_DIV_INIT: begin
				// divide magnitudes, fix the sign at the end (truncates toward zero)
				qneg_q  <= a2_q[31] ^ vcmd_q[31];
				fault_q <= vcmd_q == 32'sd0;
				dmag_q  <= vcmd_q[31] ? 32'(-vcmd_q) : 32'(vcmd_q);
				quo_q   <= a2_q[31] ? -num_w : num_w;
				rem_q   <= '0;
			end
			utt_pkg::U_DIV_ITER: begin
				rem_q <= ge ? rs - {1'b0, dmag_q} : rs;
				quo_q <= {quo_q[DW-2:0], ge};
			end
			utt_pkg::U_FIN: begin
				out_q.speed_command <= vcmd_q;
				out_q.turn_command  <= fault_q ? 32'sd0 :
					sat32({{(67 - DW){q_s[DW]}}, q_s});
				out_q.divide_fault  <= fault_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/unicycle_trajectory_tracker.sv =====
// ----------------------------------------------------------------------------
// unicycle_trajectory_tracker: differential-drive trajectory tracking controller
// Dead-reckons the pose and turns target points into speed and turn commands.
// ----------------------------------------------------------------------------
// One request is handled at a time. A start-point request (opcode 0), a
// second-point request (opcode 1) and a control step (opcode 2) each run
// their own micro-program; opcode 3 is dropped on acceptance. The run time
// of a control step is set by the single shared multiplier, the shared
// CORDIC rotator that runs twice per step, and the one-bit-per-cycle divider
// for the turn command. A finished result waits in the output register while
// the next request starts. Configuration writes take effect at once and are
// meant for idle periods.
module unicycle_trajectory_tracker #(
	parameter int FRACTION_BITS = utt_pkg::FRACTION_BITS_DEF,
	parameter int ANGLE_BITS    = utt_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS  = utt_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  utt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output utt_pkg::out_item_t out_data,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	utt_pkg::cmd_t    cmd;
	utt_pkg::status_t status;

	utt_ctrl #(
		.FRACTION_BITS (FRACTION_BITS),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (in_data.opcode),
		.status   (status),
		.cmd      (cmd)
	);

	utt_datapath #(
		.FRACTION_BITS (FRACTION_BITS),
		.ANGLE_BITS    (ANGLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
